[design/bfsp_pkg.sv]
// ----------------------------------------------------------------------------
// bfsp_pkg
// Shared types and constants for the Bellman-Ford shortest path engine.
// ----------------------------------------------------------------------------
package bfsp_pkg;

  localparam int VID_W     = 6;   // vertex number as carried on the ports
  localparam int VCNT_W    = 7;   // vertex count register
  localparam int PRED_W    = 7;   // predecessor, NO_PRED means none
  localparam int DIST_W    = 32;  // stored path distance
  localparam int COST_IN_W = 16;  // edge cost as carried on the ports
  localparam int CFG_W     = 7;   // widest configuration register
  localparam int CFG_IDX_W = 1;

  localparam logic [PRED_W-1:0] NO_PRED      = 7'd64;
  localparam logic [VCNT_W-1:0] VCOUNT_RESET = 7'd64;
  localparam logic [VID_W-1:0]  SOURCE_RESET = 6'd0;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VERTEX = 1'b1;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_START = 1'b1;

  localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

  // outcome of one edge relaxation
  typedef struct packed {
    logic                     improve;
    logic signed [DIST_W-1:0] distance;
  } relax_res_t;

  // write request into the vertex store; a write always marks the vertex reached
  typedef struct packed {
    logic                     en;
    logic [VID_W-1:0]         idx;
    logic signed [DIST_W-1:0] distance;
    logic [PRED_W-1:0]        pred;
  } vst_wr_t;

endpackage

[design/bellman_ford_shortest_paths_top.sv]
// Load request: accepted while idle, no result.
// Start request: nv passes over the E stored edges (nv vertices in use), the last
// one a check, then one result per vertex, or one negative-cycle result; edges
// are relaxed one at a time by the single relaxation unit behind the edge memory.
// Input stalls for the whole run. Reset clears control, empties the edge list and
// sets vertex count 64 and source 0; the stores themselves get no clearing pass.
// ----------------------------------------------------------------------------
// bellman_ford_shortest_paths_top
// Edge loader, run sequencer and result register for Bellman-Ford.
// ----------------------------------------------------------------------------
module bellman_ford_shortest_paths_top
  import bfsp_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 1024,
  parameter int COST_WIDTH   = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        action,
  input  logic [VID_W-1:0]            edge_from,
  input  logic [VID_W-1:0]            edge_to,
  input  logic signed [COST_IN_W-1:0] edge_cost,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [VID_W-1:0]            vertex_index,
  output logic signed [DIST_W-1:0]    path_distance,
  output logic [PRED_W-1:0]           predecessor,
  output logic                        reachable,
  output logic                        negative_cycle,
  output logic                        last_result
);

  localparam int EAW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ETW   = $clog2(MAX_EDGES + 1);
  localparam int RAW_W = (COST_WIDTH > COST_IN_W) ? COST_WIDTH : COST_IN_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INIT   = 3'd1;
  localparam logic [2:0] S_PASS   = 3'd2;
  localparam logic [2:0] S_LOOKUP = 3'd3;
  localparam logic [2:0] S_RELAX  = 3'd4;
  localparam logic [2:0] S_OUTRD  = 3'd5;
  localparam logic [2:0] S_OUTLD  = 3'd6;
  localparam logic [2:0] S_NEG    = 3'd7;

  logic [2:0]        state;
  logic [VCNT_W-1:0] vertex_count;
  logic [VID_W-1:0]  source_vertex;
  logic [ETW-1:0]    edge_total;
  logic [ETW-1:0]    ecnt;
  logic [VCNT_W-1:0] nv;
  logic [VID_W-1:0]  src;
  logic [VCNT_W-1:0] rnd;
  logic              chk;
  logic [VID_W-1:0]  vcnt;

  logic              in_acc;
  logic              out_free;
  logic [VCNT_W-1:0] nv_clamped;
  logic [ETW-1:0]    ecnt_next;
  logic [VCNT_W-1:0] rnd_next;
  logic              v_last;
  logic [RAW_W-1:0]  cost_raw;

  logic                         e_wr_en;
  logic                         e_rd_en;
  logic [EAW-1:0]               e_rd_addr;
  logic [VID_W-1:0]             e_tail;
  logic [VID_W-1:0]             e_head;
  logic signed [COST_WIDTH-1:0] e_weight;

  vst_wr_t                  v_wr;
  logic                     v_clr;
  logic                     v_rd_en;
  logic [VID_W-1:0]         v_rd_a;
  logic [VID_W-1:0]         v_rd_b;
  logic signed [DIST_W-1:0] v_dist_a;
  logic [PRED_W-1:0]        v_pred_a;
  logic                     v_flag_a;
  logic signed [DIST_W-1:0] v_dist_b;
  logic                     v_flag_b;
  relax_res_t               rr;

  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign ecnt_next = ecnt + ETW'(1);
  assign rnd_next  = rnd + VCNT_W'(1);
  assign v_last    = (({1'b0, vcnt}) + VCNT_W'(1)) == nv;
  assign cost_raw  = RAW_W'($unsigned(edge_cost));
  assign e_wr_en   = in_acc && (action == ACT_LOAD) && (edge_total < ETW'(MAX_EDGES));

  always_comb begin
    if (vertex_count == '0) begin
      nv_clamped = VCNT_W'(1);
    end else if (vertex_count > VCNT_W'(MAX_VERTICES)) begin
      nv_clamped = VCNT_W'(MAX_VERTICES);
    end else begin
      nv_clamped = vertex_count;
    end
  end

  bfsp_edge_store #(
    .MAX_EDGES  (MAX_EDGES),
    .COST_WIDTH (COST_WIDTH)
  ) u_edges (
    .clk       (clk),
    .wr_en     (e_wr_en),
    .wr_addr   (edge_total[EAW-1:0]),
    .wr_tail   (edge_from),
    .wr_head   (edge_to),
    .wr_weight ($signed(cost_raw[COST_WIDTH-1:0])),
    .rd_en     (e_rd_en),
    .rd_addr   (e_rd_addr),
    .rd_tail   (e_tail),
    .rd_head   (e_head),
    .rd_weight (e_weight)
  );

  bfsp_vertex_store #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_vertices (
    .clk       (clk),
    .rst       (rst),
    .clr_flags (v_clr),
    .wr        (v_wr),
    .rd_en     (v_rd_en),
    .rd_idx_a  (v_rd_a),
    .rd_idx_b  (v_rd_b),
    .dist_a    (v_dist_a),
    .pred_a    (v_pred_a),
    .flag_a    (v_flag_a),
    .dist_b    (v_dist_b),
    .flag_b    (v_flag_b)
  );

  bfsp_relax_unit #(
    .COST_WIDTH (COST_WIDTH)
  ) u_relax (
    .vcount (nv),
    .tail   (e_tail),
    .head   (e_head),
    .flag_a (v_flag_a),
    .flag_b (v_flag_b),
    .dist_a (v_dist_a),
    .dist_b (v_dist_b),
    .weight (e_weight),
    .res    (rr)
  );

  // memory control for each sequencer step
  always_comb begin
    e_rd_en   = 1'b0;
    e_rd_addr = '0;
    v_clr     = 1'b0;
    v_rd_en   = 1'b0;
    v_rd_a    = e_tail;
    v_rd_b    = e_head;
    v_wr      = '0;
    case (state)
      S_INIT: begin
        v_clr         = 1'b1;
        v_wr.en       = ({1'b0, src} < nv);
        v_wr.idx      = src;
        v_wr.distance = '0;
        v_wr.pred     = NO_PRED;
      end
      S_PASS: begin
        e_rd_en = (edge_total != '0);
      end
      S_LOOKUP: begin
        v_rd_en = 1'b1;
      end
      S_RELAX: begin
        e_rd_en       = (ecnt_next < edge_total);
        e_rd_addr     = ecnt_next[EAW-1:0];
        v_wr.en       = rr.improve && !chk;
        v_wr.idx      = e_head;
        v_wr.distance = rr.distance;
        v_wr.pred     = {1'b0, e_tail};
      end
      S_OUTRD: begin
        v_rd_en = 1'b1;
        v_rd_a  = vcnt;
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= VCOUNT_RESET;
      source_vertex <= SOURCE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_VERTEX_COUNT:  vertex_count  <= cfg_data;
        REG_SOURCE_VERTEX: source_vertex <= cfg_data[VID_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      edge_total <= '0;
      ecnt       <= '0;
      rnd        <= '0;
      chk        <= 1'b0;
      vcnt       <= '0;
      nv         <= VCNT_W'(1);
      src        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (e_wr_en) begin
            edge_total <= edge_total + ETW'(1);
          end
          if (in_acc && (action == ACT_START)) begin
            nv    <= nv_clamped;
            src   <= source_vertex;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          rnd   <= '0;
          chk   <= (nv == VCNT_W'(1));
          state <= S_PASS;
        end
        S_PASS: begin
          ecnt <= '0;
          if (edge_total != '0) begin
            state <= S_LOOKUP;
          end else if (chk) begin
            vcnt  <= '0;
            state <= S_OUTRD;
          end else begin
            rnd   <= rnd_next;
            chk   <= (rnd_next == nv - VCNT_W'(1));
            state <= S_PASS;
          end
        end
        S_LOOKUP: begin
          state <= S_RELAX;
        end
        S_RELAX: begin
          ecnt <= ecnt_next;
          if (chk && rr.improve) begin
            state <= S_NEG;
          end else if (ecnt_next != edge_total) begin
            state <= S_LOOKUP;
          end else if (chk) begin
            vcnt  <= '0;
            state <= S_OUTRD;
          end else begin
            rnd   <= rnd_next;
            chk   <= (rnd_next == nv - VCNT_W'(1));
            state <= S_PASS;
          end
        end
        S_OUTRD: begin
          state <= S_OUTLD;
        end
        S_OUTLD: begin
          if (out_free) begin
            if (v_last) begin
              edge_total <= '0;
              state      <= S_IDLE;
            end else begin
              vcnt  <= vcnt + VID_W'(1);
              state <= S_OUTRD;
            end
          end
        end
        S_NEG: begin
          if (out_free) begin
            edge_total <= '0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free && ((state == S_OUTLD) || (state == S_NEG))) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && (state == S_OUTLD)) begin
      vertex_index   <= vcnt;
      path_distance  <= v_flag_a ? v_dist_a : '0;
      predecessor    <= v_flag_a ? v_pred_a : NO_PRED;
      reachable      <= v_flag_a;
      negative_cycle <= 1'b0;
      last_result    <= v_last;
    end else if (out_free && (state == S_NEG)) begin
      vertex_index   <= '0;
      path_distance  <= '0;
      predecessor    <= '0;
      reachable      <= 1'b0;
      negative_cycle <= 1'b1;
      last_result    <= 1'b1;
    end
  end

  a_neg_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && negative_cycle |-> last_result && !reachable &&
      (path_distance == '0) && (predecessor == '0))
    else $error("negative cycle result carries non-zero fields");

  a_unreached: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reachable |-> (path_distance == '0) &&
      (negative_cycle || (predecessor == NO_PRED)))
    else $error("unreached vertex reports a distance or predecessor");

  a_edge_bound: assert property (@(posedge clk) disable iff (rst)
    edge_total <= ETW'(MAX_EDGES))
    else $error("edge count beyond store depth");

  a_relax_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_RELAX) || (state == S_LOOKUP) |-> ecnt < edge_total)
    else $error("relaxation past the last stored edge");

  a_start_holds: assert property (@(posedge clk) disable iff (rst)
    in_acc && (action == ACT_START) |=> in_stall)
    else $error("input not held off after start request");

endmodule

[design/bfsp_edge_store.sv]
// ----------------------------------------------------------------------------
// bfsp_edge_store
// Edge list memory: tail, head and cost, one write and one registered read.
// ----------------------------------------------------------------------------
module bfsp_edge_store
  import bfsp_pkg::*;
#(
  parameter int MAX_EDGES  = 1024,
  parameter int COST_WIDTH = 16,
  localparam int EAW       = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [EAW-1:0]               wr_addr,
  input  logic [VID_W-1:0]             wr_tail,
  input  logic [VID_W-1:0]             wr_head,
  input  logic signed [COST_WIDTH-1:0] wr_weight,
  input  logic                         rd_en,
  input  logic [EAW-1:0]               rd_addr,
  output logic [VID_W-1:0]             rd_tail,
  output logic [VID_W-1:0]             rd_head,
  output logic signed [COST_WIDTH-1:0] rd_weight
);

  logic [VID_W-1:0]      tail_mem   [MAX_EDGES];
  logic [VID_W-1:0]      head_mem   [MAX_EDGES];
  logic [COST_WIDTH-1:0] weight_mem [MAX_EDGES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tail_mem[wr_addr]   <= wr_tail;
      head_mem[wr_addr]   <= wr_head;
      weight_mem[wr_addr] <= wr_weight;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_tail   <= tail_mem[rd_addr];
      rd_head   <= head_mem[rd_addr];
      rd_weight <= $signed(weight_mem[rd_addr]);
    end
  end

endmodule

[design/bfsp_vertex_store.sv]
// ----------------------------------------------------------------------------
// bfsp_vertex_store
// Per-vertex distance and predecessor memory with reached flags.
// ----------------------------------------------------------------------------
module bfsp_vertex_store
  import bfsp_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clr_flags,
  input  vst_wr_t                  wr,
  input  logic                     rd_en,
  input  logic [VID_W-1:0]         rd_idx_a,
  input  logic [VID_W-1:0]         rd_idx_b,
  output logic signed [DIST_W-1:0] dist_a,
  output logic [PRED_W-1:0]        pred_a,
  output logic                     flag_a,
  output logic signed [DIST_W-1:0] dist_b,
  output logic                     flag_b
);

  localparam int VW = $clog2(MAX_VERTICES);

  logic [DIST_W-1:0]       dist_mem [MAX_VERTICES];
  logic [PRED_W-1:0]       pred_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] reached;
  logic [MAX_VERTICES-1:0] reached_next;
  logic                    a_in, b_in;

  assign a_in = ({1'b0, rd_idx_a} < VCNT_W'(MAX_VERTICES));
  assign b_in = ({1'b0, rd_idx_b} < VCNT_W'(MAX_VERTICES));

  // clear first, then mark the vertex being written
  always_comb begin
    reached_next = clr_flags ? '0 : reached;
    if (wr.en) begin
      reached_next[wr.idx[VW-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      dist_mem[wr.idx[VW-1:0]] <= wr.distance;
      pred_mem[wr.idx[VW-1:0]] <= wr.pred;
    end
    if (rd_en) begin
      dist_a <= $signed(dist_mem[rd_idx_a[VW-1:0]]);
      pred_a <= pred_mem[rd_idx_a[VW-1:0]];
      dist_b <= $signed(dist_mem[rd_idx_b[VW-1:0]]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reached <= '0;
      flag_a  <= 1'b0;
      flag_b  <= 1'b0;
    end else begin
      reached <= reached_next;
      if (rd_en) begin
        flag_a <= a_in && reached[rd_idx_a[VW-1:0]];
        flag_b <= b_in && reached[rd_idx_b[VW-1:0]];
      end
    end
  end

endmodule

[design/bfsp_relax_unit.sv]
// ----------------------------------------------------------------------------
// bfsp_relax_unit
// Shared relaxation unit: candidate sum, improvement compare, saturation.
// ----------------------------------------------------------------------------
module bfsp_relax_unit
  import bfsp_pkg::*;
#(
  parameter int COST_WIDTH = 16
) (
  input  logic [VCNT_W-1:0]            vcount,
  input  logic [VID_W-1:0]             tail,
  input  logic [VID_W-1:0]             head,
  input  logic                         flag_a,
  input  logic                         flag_b,
  input  logic signed [DIST_W-1:0]     dist_a,
  input  logic signed [DIST_W-1:0]     dist_b,
  input  logic signed [COST_WIDTH-1:0] weight,
  output relax_res_t                   res
);

  logic signed [DIST_W:0] cand;
  logic signed [DIST_W:0] cur;
  logic                   in_range;

  always_comb begin
    cand     = (DIST_W+1)'(dist_a) + (DIST_W+1)'(weight);
    cur      = (DIST_W+1)'(dist_b);
    in_range = ({1'b0, tail} < vcount) && ({1'b0, head} < vcount);
    // unreached tail never relaxes; an in-range unreached head improves
    res.improve = in_range && flag_a && (!flag_b || (cur > cand));
    if (cand[DIST_W] != cand[DIST_W-1]) begin
      res.distance = cand[DIST_W] ? DIST_MIN : DIST_MAX;
    end else begin
      res.distance = cand[DIST_W-1:0];
    end
  end

endmodule

[bench/bf_path_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bf_path_checker
// Watches the configuration port, the request channel and the result channel of the
// Bellman-Ford engine, keeps its own edge list and settings, works out the
// results of every start request and compares each returned result with them.
// ----------------------------------------------------------------------------
module bf_path_checker
  import bfsp_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        action,
  input  logic [VID_W-1:0]            edge_from,
  input  logic [VID_W-1:0]            edge_to,
  input  logic signed [COST_IN_W-1:0] edge_cost,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [VID_W-1:0]            vertex_index,
  input  logic signed [DIST_W-1:0]    path_distance,
  input  logic [PRED_W-1:0]           predecessor,
  input  logic                        reachable,
  input  logic                        negative_cycle,
  input  logic                        last_result,
  output int                          mismatch_count,
  output int                          paths_outstanding
);

  typedef struct packed {
    logic [VID_W-1:0]         vertex;
    logic signed [DIST_W-1:0] distance;
    logic [PRED_W-1:0]        pred;
    logic                     reached;
    logic                     neg_cycle;
    logic                     last;
  } path_result_t;

  logic [VID_W-1:0]  edge_tails   [MAX_EDGES];
  logic [VID_W-1:0]  edge_heads   [MAX_EDGES];
  longint            edge_weights [MAX_EDGES];
  int                edge_fill;

  longint            vertex_dist    [MAX_VERTICES];
  logic [PRED_W-1:0] vertex_pred    [MAX_VERTICES];
  bit                vertex_reached [MAX_VERTICES];

  logic [VCNT_W-1:0] vcount_setting;
  logic [VID_W-1:0]  source_setting;

  path_result_t      expected_paths [$];

  function automatic longint clamp_distance(input longint value);
    if (value > longint'(DIST_MAX)) return longint'(DIST_MAX);
    if (value < longint'(DIST_MIN)) return longint'(DIST_MIN);
    return value;
  endfunction

  // one pass over the edge list in load order; without apply, only report
  // whether some edge could still shorten its head
  function automatic bit sweep_edges(input int nv, input bit apply);
    int     tail_v;
    int     head_v;
    longint cand;
    for (int e = 0; e < edge_fill; e++) begin
      tail_v = int'(edge_tails[e]);
      head_v = int'(edge_heads[e]);
      if (tail_v >= nv || head_v >= nv || !vertex_reached[tail_v]) continue;
      cand = vertex_dist[tail_v] + edge_weights[e];
      if (!vertex_reached[head_v] || vertex_dist[head_v] > cand) begin
        if (!apply) return 1'b1;
        vertex_dist[head_v]    = clamp_distance(cand);
        vertex_pred[head_v]    = PRED_W'(tail_v);
        vertex_reached[head_v] = 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic predict_paths();
    int           nv;
    path_result_t res;
    nv = (vcount_setting == 0) ? 1 :
         (vcount_setting > MAX_VERTICES) ? MAX_VERTICES : int'(vcount_setting);
    for (int v = 0; v < nv; v++) begin
      vertex_dist[v]    = 0;
      vertex_pred[v]    = NO_PRED;
      vertex_reached[v] = 1'b0;
    end
    if (source_setting < nv) vertex_reached[source_setting] = 1'b1;
    for (int r = 0; r + 1 < nv; r++) void'(sweep_edges(nv, 1'b1));
    if (sweep_edges(nv, 1'b0)) begin
      res           = '0;
      res.neg_cycle = 1'b1;
      res.last      = 1'b1;
      expected_paths.push_back(res);
    end else begin
      for (int v = 0; v < nv; v++) begin
        res          = '0;
        res.vertex   = v[VID_W-1:0];
        res.reached  = vertex_reached[v];
        res.distance = vertex_reached[v] ? vertex_dist[v][DIST_W-1:0] : '0;
        res.pred     = vertex_reached[v] ? vertex_pred[v] : NO_PRED;
        res.last     = (v + 1 == nv);
        expected_paths.push_back(res);
      end
    end
    edge_fill = 0;
  endtask

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t %s mismatch: expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    path_result_t want;
    if (rst) begin
      vcount_setting = VCOUNT_RESET;
      source_setting = SOURCE_RESET;
      edge_fill      = 0;
      mismatch_count = 0;
      expected_paths.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_VERTEX_COUNT) vcount_setting = cfg_data[VCNT_W-1:0];
        else if (cfg_index == REG_SOURCE_VERTEX) source_setting = cfg_data[VID_W-1:0];
      end
      if (in_valid && !in_stall) begin
        if (action == ACT_LOAD) begin
          // drop loads once the store is full
          if (edge_fill < MAX_EDGES) begin
            edge_tails[edge_fill]   = edge_from;
            edge_heads[edge_fill]   = edge_to;
            edge_weights[edge_fill] = longint'(edge_cost);
            edge_fill++;
          end
        end else begin
          predict_paths();
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_paths.size() == 0) begin
          mismatch_count++;
          $display("%0t unexpected result: expected none, got vertex %0d", $time,
                   vertex_index);
        end else begin
          want = expected_paths.pop_front();
          check_field("vertex_index", want.vertex, vertex_index);
          check_field("path_distance", want.distance, path_distance);
          check_field("predecessor", want.pred, predecessor);
          check_field("reachable", want.reached, reachable);
          check_field("negative_cycle", want.neg_cycle, negative_cycle);
          check_field("last_result", want.last, last_result);
        end
      end
    end
    paths_outstanding = expected_paths.size();
  end

endmodule

[bench/tb_bellman_ford_shortest_paths_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bellman_ford_shortest_paths_top
// Drives edge loads, start requests and register writes into the Bellman-Ford
// engine with bursty input and a stalling receiver; the checker beside the
// block predicts and compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_bellman_ford_shortest_paths_top;
  import bfsp_pkg::*;

  localparam int VERTEX_LIMIT    = 64;
  localparam int RANDOM_ITEMS    = 210;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 50;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_ROUND      = 6;
  localparam int PAUSE_ROUND     = 10;
  localparam int CYCLE_LIMIT     = 1_000_000;

  logic                        clk;
  logic                        rst;
  logic                        cfg_write;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_W-1:0]            cfg_data;
  logic                        in_valid;
  logic                        in_stall;
  logic                        action;
  logic [VID_W-1:0]            edge_from;
  logic [VID_W-1:0]            edge_to;
  logic signed [COST_IN_W-1:0] edge_cost;
  logic                        out_valid;
  logic                        out_stall;
  logic [VID_W-1:0]            vertex_index;
  logic signed [DIST_W-1:0]    path_distance;
  logic [PRED_W-1:0]           predecessor;
  logic                        reachable;
  logic                        negative_cycle;
  logic                        last_result;

  int mismatch_count;
  int paths_outstanding;
  int cycle_count;
  int hold_off_ticket;
  int burst_left;
  int items_sent;
  int nv_in_use;

  bellman_ford_shortest_paths_top u_top (.*);

  bf_path_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: changing stall density, plus a long hold-off on request
  initial begin : receiver
    int served;
    int mode_left;
    int stall_pct;
    served    = 0;
    mode_left = 0;
    stall_pct = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_ticket != served) begin
        served = hold_off_ticket;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 150);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      mode_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // offer one request; returns at the falling edge after acceptance with
  // valid still high so that a burst runs on without a gap
  task automatic offer(input logic act, input logic [VID_W-1:0] from_v,
                       input logic [VID_W-1:0] to_v,
                       input logic signed [COST_IN_W-1:0] cost);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    action    <= act;
    edge_from <= from_v;
    edge_to   <= to_v;
    edge_cost <= cost;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic start_run();
    offer(ACT_START, VID_W'($urandom_range(0, 63)), VID_W'($urandom_range(0, 63)),
          COST_IN_W'($urandom_range(0, 65535)));
  endtask

  // wait until every result has come, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (paths_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input int vcount, input int source);
    settle();
    write_reg(REG_VERTEX_COUNT, vcount[CFG_W-1:0]);
    write_reg(REG_SOURCE_VERTEX, source[CFG_W-1:0]);
    nv_in_use = (vcount == 0) ? 1 : (vcount > VERTEX_LIMIT) ? VERTEX_LIMIT : vcount;
  endtask

  initial begin : stimulus
    int round;
    int edges;
    int vcount;
    int eff;
    logic [VID_W-1:0]            from_v;
    logic [VID_W-1:0]            to_v;
    logic signed [COST_IN_W-1:0] cost;

    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    action          = ACT_LOAD;
    edge_from       = '0;
    edge_to         = '0;
    edge_cost       = '0;
    hold_off_ticket = 0;
    burst_left      = 0;
    items_sent      = 0;
    nv_in_use       = VERTEX_LIMIT;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: a chain with extreme costs and a branch off an unreached tail
    offer(ACT_LOAD, 0, 1, 5);
    offer(ACT_LOAD, 1, 2, -3);
    offer(ACT_LOAD, 2, 63, 16'sh7FFF);
    offer(ACT_LOAD, 63, 62, 16'sh8000);
    offer(ACT_LOAD, 5, 6, 1);
    offer(ACT_LOAD, 0, 2, 10);
    start_run();
    // reachable negative cycle
    offer(ACT_LOAD, 0, 3, 0);
    offer(ACT_LOAD, 3, 4, 1);
    offer(ACT_LOAD, 4, 3, -2);
    start_run();
    // empty edge list
    start_run();
    // zero vertices counts as one; edge to a vertex out of range
    configure(0, 0);
    offer(ACT_LOAD, 0, 1, 7);
    start_run();
    // count above the maximum, source at the top vertex
    configure(127, 63);
    offer(ACT_LOAD, 63, 0, -5);
    offer(ACT_LOAD, 0, 1, 16'sh8000);
    start_run();
    // source out of range: nothing reached
    configure(5, 9);
    offer(ACT_LOAD, 9, 1, 3);
    offer(ACT_LOAD, 0, 1, 3);
    start_run();
    // negative self-loop at the source
    configure(2, 0);
    offer(ACT_LOAD, 0, 0, -1);
    start_run();

    round = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (round % 4 == 0) begin
        case ($urandom_range(0, 9))
          0: vcount = 0;
          1: vcount = 1;
          2: vcount = 64;
          3: vcount = $urandom_range(65, 127);
          default: vcount = $urandom_range(2, 12);
        endcase
        eff = (vcount == 0) ? 1 : (vcount > VERTEX_LIMIT) ? VERTEX_LIMIT : vcount;
        configure(vcount, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) :
                                                         $urandom_range(0, eff - 1));
      end
      if (round == PAUSE_ROUND) settle();
      edges = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 12);
      for (int i = 0; i < edges; i++) begin
        if ($urandom_range(0, 6) == 0) begin
          from_v = VID_W'($urandom_range(0, 63));
          to_v   = VID_W'($urandom_range(0, 63));
        end else begin
          from_v = VID_W'($urandom_range(0, nv_in_use - 1));
          to_v   = VID_W'($urandom_range(0, nv_in_use - 1));
        end
        if ($urandom_range(0, 9) == 0) cost = COST_IN_W'($urandom_range(0, 65535));
        else cost = COST_IN_W'($urandom_range(0, 60) - 10);
        offer(ACT_LOAD, from_v, to_v, cost);
      end
      // hold the receiver off while the next round's loads queue up behind the run
      if (round == HOLD_ROUND) hold_off_ticket++;
      start_run();
      round++;
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (paths_outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
